/* hw/rtl/sample_frame_packer_defines.svh */
// Assertion macros used by the sample frame packer serializer.
`ifndef SAMPLE_FRAME_PACKER_DEFINES_SVH
`define SAMPLE_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sfp_pkg.sv */
// Package with shared constants and types of the sample frame packer.
package sfp_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int IN_CHANNELS       = 8;   // channel words in each input transaction
    localparam int WORD_W            = 32;
    localparam int BYTE_W            = 8;
    localparam int CNT_W             = 6;   // popcount of one 32-bit word
    localparam int SUM_W             = 8;   // checksum wraps modulo 256
    localparam int IN_DATA_W         = (IN_CHANNELS + 1) * WORD_W;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 8;
    localparam int BYTES_PER_WORD    = WORD_W / BYTE_W;
    localparam int BIDX_W            = $clog2(BYTES_PER_WORD);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h00;

    typedef enum logic {
        ST_IDLE,
        ST_DATA
    } t_ser_state;

endpackage

/* hw/rtl/sample_frame_packer.sv */
// Sample frame packer top level: input hold stage, bit-count lanes, merge, serializer.
//
// Each input transaction carries eight channel words and a timestamp word and
// becomes one byte frame on the master side: a zero header, the timestamp (in
// on-demand mode), four little-endian bytes per enabled channel, and a
// checksum byte (bit count of the frame, modulo 256) marked by tlast. A frame
// of N bytes (2 to 38) leaves at one byte per cycle while tready is high,
// through the byte-wide output serializer; the next transaction is taken
// into the hold stage while the current frame is still going out, and
// frames follow each other with no idle cycle. Bit counts of all words are
// formed in parallel lanes as a transaction is taken. Configuration is
// sampled when a transaction is taken and must only be written while the
// block is idle.
module sample_frame_packer
    import sfp_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample set input
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata fields from bit 0: chan0_word .. chan7_word, stamp_word (32 bits each)
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Frame byte output
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata fields from bit 0: frame_byte (8 bits)
    output logic [BYTE_W-1:0]     o_m_axis_tdata,
    // tlast: frame_end
    output logic                  o_m_axis_tlast
);

    // Slot 0 is the timestamp, slot k is channel k-1
    localparam int SLOTS = CHANNEL_COUNT + 1;

    logic [IN_CHANNELS-1:0]  r_mask;
    logic                    r_mode;

    logic                    r_hold_valid;
    logic [WORD_W-1:0]       r_hold_words [SLOTS];
    logic [CNT_W-1:0]        r_hold_cnt   [SLOTS];
    logic [SLOTS-1:0]        r_hold_pend;

    logic [WORD_W-1:0]       in_words [SLOTS];
    logic [SLOTS-1:0]        in_en;
    logic [CNT_W-1:0]        lane_cnt [SLOTS];
    logic [SUM_W-1:0]        frame_sum;
    logic                    take;
    logic                    in_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_MASK: r_mask <= i_cfg_data;
                CFG_IDX_MODE: r_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Unpack input words into slots with their enables
    always_comb begin
        in_words[0] = i_s_axis_tdata[IN_CHANNELS*WORD_W +: WORD_W];
        in_en[0]    = r_mode;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            in_words[c+1] = i_s_axis_tdata[c*WORD_W +: WORD_W];
            in_en[c+1]    = r_mask[c];
        end
    end

    // Bit-count lanes
    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        sfp_lane u_lane (
            .i_word (in_words[g]),
            .i_en   (in_en[g]),
            .o_cnt  (lane_cnt[g])
        );
    end

    // Hold stage between input and serializer
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_hold_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (in_accept) begin
            r_hold_valid <= 1'b1;
        end else if (take) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hold_pend <= in_en;
            for (int s = 0; s < SLOTS; s++) begin
                r_hold_words[s] <= in_words[s];
                r_hold_cnt[s]   <= lane_cnt[s];
            end
        end
    end

    sfp_merge #(
        .SLOTS (SLOTS)
    ) u_merge (
        .i_cnt (r_hold_cnt),
        .o_sum (frame_sum)
    );

    sfp_serializer #(
        .SLOTS (SLOTS)
    ) u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold_valid (r_hold_valid),
        .i_words      (r_hold_words),
        .i_pend       (r_hold_pend),
        .i_sum        (frame_sum),
        .o_take       (take),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

/* hw/rtl/sfp_lane.sv */
// One lane: masked bit count of a single 32-bit frame word.
module sfp_lane
    import sfp_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_en,
    output logic [CNT_W-1:0]  o_cnt
);

    localparam int NIB_N = WORD_W / 4;

    logic [2:0]       nib_cnt [NIB_N];
    logic [CNT_W-1:0] total;

    // Nibble counts, then a sum of the nibble counts
    always_comb begin
        for (int n = 0; n < NIB_N; n++) begin
            nib_cnt[n] = 3'(i_word[4*n]) + 3'(i_word[4*n+1])
                       + 3'(i_word[4*n+2]) + 3'(i_word[4*n+3]);
        end
        total = '0;
        for (int n = 0; n < NIB_N; n++) begin
            total = total + CNT_W'(nib_cnt[n]);
        end
        o_cnt = i_en ? total : '0;
    end

endmodule

/* hw/rtl/sfp_merge.sv */
// Merge stage: adds the lane bit counts into the frame checksum.
module sfp_merge
    import sfp_pkg::*;
#(
    parameter int SLOTS = CHANNEL_COUNT_DEF + 1
) (
    input  logic [CNT_W-1:0] i_cnt [SLOTS],
    output logic [SUM_W-1:0] o_sum
);

    // Wrapping sum; the header byte adds nothing
    always_comb begin
        o_sum = '0;
        for (int s = 0; s < SLOTS; s++) begin
            o_sum = o_sum + SUM_W'(i_cnt[s]);
        end
    end

endmodule

/* hw/rtl/sfp_serializer.sv */
// Frame serializer: emits header, enabled words byte by byte, then checksum.
`include "sample_frame_packer_defines.svh"

module sfp_serializer
    import sfp_pkg::*;
#(
    parameter int SLOTS = CHANNEL_COUNT_DEF + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold_valid,
    input  logic [WORD_W-1:0] i_words [SLOTS],
    input  logic [SLOTS-1:0]  i_pend,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    localparam int SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_ser_state        r_state, n_state;
    logic [SLOTS-1:0]  r_pend, n_pend;
    logic [BIDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic [WORD_W-1:0] r_words [SLOTS];

    logic              advance;
    logic              take;
    logic [SEL_W-1:0]  sel;
    logic [WORD_W-1:0] cur_word;
    logic [BYTE_W-1:0] cur_byte;

    // Output register moves when empty or drained this cycle
    assign advance = !r_out_valid || i_ready;
    assign take    = advance && (r_state == ST_IDLE) && i_hold_valid;

    // Lowest pending slot goes first
    always_comb begin
        sel = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_pend[s]) begin
                sel = SEL_W'(s);
            end
        end
    end

    assign cur_word = r_words[sel];
    assign cur_byte = cur_word[BYTE_W*r_byte_idx +: BYTE_W];

    // Next state and output byte
    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_byte_idx  = r_byte_idx;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (advance) begin
            n_out_valid = 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_hold_valid) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = HEADER_BYTE;
                        n_out_last  = 1'b0;
                        n_pend      = i_pend;
                        n_sum       = i_sum;
                        n_byte_idx  = '0;
                        n_state     = ST_DATA;
                    end
                end
                ST_DATA: begin
                    n_out_valid = 1'b1;
                    if (r_pend == '0) begin
                        n_out_byte = r_sum;
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out_byte = cur_byte;
                        n_out_last = 1'b0;
                        n_byte_idx = r_byte_idx + 1'b1;
                        if (r_byte_idx == BIDX_W'(BYTES_PER_WORD - 1)) begin
                            n_pend[sel] = 1'b0;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_byte_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_byte_idx  <= n_byte_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (take) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_words[s] <= i_words[s];
            end
        end
    end

    assign o_take  = take;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    // Checks
    `SFP_ASSERT_NEXT(a_load_emits_header, i_clk, i_rst_n, take,
        r_out_valid && (r_out_byte == HEADER_BYTE) && !r_out_last,
        "frame load did not put out the header byte")
    `SFP_ASSERT_NOW(a_last_closes_frame, i_clk, i_rst_n, r_out_valid && r_out_last,
        r_state == ST_IDLE, "checksum byte shown while frame still in progress")
    `SFP_ASSERT_NOW(a_idle_nothing_pending, i_clk, i_rst_n, r_state == ST_IDLE,
        r_pend == '0, "words left pending in idle")
    `SFP_ASSERT_NOW(a_mid_word_pending, i_clk, i_rst_n, r_byte_idx != '0,
        r_pend != '0, "byte index moved with no word pending")

endmodule
